// ===== rtl/rpt_pkg.sv =====
// Package for the regex pattern tokenizer: result record, token and status
// codes, character constants and queue sizing. No dependencies.
`default_nettype none

package rpt_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = 3;
  localparam int LVL_W      = 4;

  localparam logic [3:0] TK_LIT   = 4'd0;
  localparam logic [3:0] TK_OPEN  = 4'd1;
  localparam logic [3:0] TK_CLOSE = 4'd2;
  localparam logic [3:0] TK_ALT   = 4'd5;
  localparam logic [3:0] TK_STAR  = 4'd6;
  localparam logic [3:0] TK_PLUS  = 4'd7;
  localparam logic [3:0] TK_QUEST = 4'd8;
  localparam logic [3:0] TK_RANGE = 4'd9;
  localparam logic [3:0] TK_WILD  = 4'd10;
  localparam logic [3:0] TK_EMPTY = 4'd11;
  localparam logic [3:0] TK_SPACE = 4'd12;
  localparam logic [3:0] TK_FINAL = 4'd13;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_TRAIL_ESC     = 3'd1;
  localparam logic [2:0] ST_UNFINISHED    = 3'd2;
  localparam logic [2:0] ST_BAD_RANGE     = 3'd3;
  localparam logic [2:0] ST_STRAY_BRACKET = 3'd4;
  localparam logic [2:0] ST_EXTRA_CLOSE   = 3'd5;
  localparam logic [2:0] ST_EXTRA_OPEN    = 3'd6;
  localparam logic [2:0] ST_OPEN_QUOTE    = 3'd7;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_QUEST     = 8'h3F;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_LOW_S     = 8'h73;
  localparam logic [7:0] CH_LOW_E     = 8'h65;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  typedef struct packed {
    logic [3:0] token;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       starts_literal;
    logic [2:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]   count;
    res_t [MAX_RES-1:0]     item;
  } step_t;

  function automatic res_t mk_res(input logic [3:0] token, input logic [7:0] c1,
                                  input logic [7:0] c2, input logic start,
                                  input logic [2:0] status);
    res_t r;
    r.token          = token;
    r.first_char     = c1;
    r.second_char    = c2;
    r.starts_literal = start;
    r.status         = status;
    r.last           = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpt_core.sv =====
// Tokenizer state and per-byte step logic: turns one accepted byte into up
// to three results. Depends on rpt_pkg.
`default_nettype none

module rpt_core
  import rpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] ch,
  input  wire logic       end_of_text,
  output step_t           step
);

  typedef enum logic [2:0] {
    M_NORMAL, M_ESCAPE, M_RANGE1, M_RANGE2, M_RANGE3, M_RANGE4
  } mode_t;

  mode_t                 mode_r, mode_nxt;
  logic                  quotes_r, quotes_nxt;
  logic [7:0]            lo_r, lo_nxt;
  logic [7:0]            hi_r, hi_nxt;
  logic                  mal_r, mal_nxt;
  logic                  lit_r, lit_nxt;
  logic [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [2:0]            err_r, err_nxt;

  always_comb begin
    logic [RES_CNT_W-1:0] cnt;
    res_t [MAX_RES-1:0]   res_v;
    logic [2:0]           st;
    mode_nxt   = mode_r;
    quotes_nxt = quotes_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mal_nxt    = mal_r;
    lit_nxt    = lit_r;
    depth_nxt  = depth_r;
    err_nxt    = err_r;
    cnt        = '0;
    res_v      = '0;
    st         = ST_OK;

    if (err_r == ST_OK) begin
      unique case (mode_r)
        M_ESCAPE: begin
          mode_nxt = M_NORMAL;
          if (ch == CH_QUOTE || ch == CH_BACKSLASH) begin
            res_v[cnt] = mk_res(TK_LIT, ch, 8'd0, ~lit_nxt, ST_OK);
            lit_nxt = 1'b1;
            cnt = cnt + 2'd1;
          end else if (quotes_r) begin
            res_v[cnt] = mk_res(TK_LIT, CH_BACKSLASH, 8'd0, ~lit_nxt, ST_OK);
            lit_nxt = 1'b1;
            cnt = cnt + 2'd1;
            res_v[cnt] = mk_res(TK_LIT, ch, 8'd0, 1'b0, ST_OK);
            cnt = cnt + 2'd1;
          end else begin
            unique case (ch)
              CH_LOW_S: begin
                lit_nxt = 1'b0;
                res_v[cnt] = mk_res(TK_SPACE, 8'd0, 8'd0, 1'b0, ST_OK);
                cnt = cnt + 2'd1;
              end
              CH_LOW_E: begin
                lit_nxt = 1'b0;
                res_v[cnt] = mk_res(TK_EMPTY, 8'd0, 8'd0, 1'b0, ST_OK);
                cnt = cnt + 2'd1;
              end
              CH_LOW_T, CH_LOW_R, CH_LOW_N: begin
                res_v[cnt] = mk_res(TK_LIT, (ch == CH_LOW_T) ? CH_TAB :
                                    (ch == CH_LOW_R) ? CH_CR : CH_LF,
                                    8'd0, ~lit_nxt, ST_OK);
                lit_nxt = 1'b1;
                cnt = cnt + 2'd1;
              end
              default: begin
              end
            endcase
          end
        end
        M_RANGE1: begin
          lo_nxt   = ch;
          mode_nxt = M_RANGE2;
        end
        M_RANGE2: begin
          mal_nxt  = (ch != CH_DASH);
          mode_nxt = M_RANGE3;
        end
        M_RANGE3: begin
          hi_nxt   = ch;
          mode_nxt = M_RANGE4;
        end
        M_RANGE4: begin
          mode_nxt = M_NORMAL;
          if (mal_r || ch != CH_RBRACKET) begin
            err_nxt = ST_BAD_RANGE;
          end else begin
            res_v[cnt] = mk_res(TK_RANGE, lo_r, hi_r, 1'b0, ST_OK);
            cnt = cnt + 2'd1;
          end
        end
        M_NORMAL: begin
          if (ch == CH_BACKSLASH) begin
            mode_nxt = M_ESCAPE;
          end else if (ch == CH_QUOTE) begin
            quotes_nxt = ~quotes_r;
          end else if (quotes_r) begin
            res_v[cnt] = mk_res(TK_LIT, ch, 8'd0, ~lit_nxt, ST_OK);
            lit_nxt = 1'b1;
            cnt = cnt + 2'd1;
          end else begin
            unique case (ch)
              CH_LBRACKET: begin
                lit_nxt  = 1'b0;
                mode_nxt = M_RANGE1;
              end
              CH_RBRACKET: err_nxt = ST_STRAY_BRACKET;
              CH_LPAREN, CH_RPAREN, CH_BAR, CH_STAR, CH_PLUS, CH_QUEST,
              CH_DOT: begin
                lit_nxt = 1'b0;
                if (ch == CH_LPAREN) depth_nxt = depth_r + DEPTH_BITS'(1);
                if (ch == CH_RPAREN) depth_nxt = depth_r - DEPTH_BITS'(1);
                res_v[cnt] = mk_res((ch == CH_LPAREN) ? TK_OPEN :
                                    (ch == CH_RPAREN) ? TK_CLOSE :
                                    (ch == CH_BAR)    ? TK_ALT :
                                    (ch == CH_STAR)   ? TK_STAR :
                                    (ch == CH_PLUS)   ? TK_PLUS :
                                    (ch == CH_QUEST)  ? TK_QUEST : TK_WILD,
                                    8'd0, 8'd0, 1'b0, ST_OK);
                cnt = cnt + 2'd1;
              end
              default: begin
                res_v[cnt] = mk_res(TK_LIT, ch, 8'd0, ~lit_nxt, ST_OK);
                lit_nxt = 1'b1;
                cnt = cnt + 2'd1;
              end
            endcase
          end
        end
        default: mode_nxt = M_NORMAL;
      endcase
    end

    if (end_of_text) begin
      st = err_nxt;
      if (st == ST_OK) begin
        priority if (mode_nxt == M_ESCAPE) begin
          st = ST_TRAIL_ESC;
        end else if (mode_nxt != M_NORMAL) begin
          st = ST_UNFINISHED;
        end else if (depth_nxt != '0) begin
          st = depth_nxt[DEPTH_BITS-1] ? ST_EXTRA_CLOSE : ST_EXTRA_OPEN;
        end else if (quotes_nxt) begin
          st = ST_OPEN_QUOTE;
        end
      end
      res_v[cnt] = mk_res(TK_FINAL, 8'd0, 8'd0, 1'b0, st);
      cnt = cnt + 2'd1;
      mode_nxt   = M_NORMAL;
      quotes_nxt = 1'b0;
      lo_nxt     = 8'd0;
      hi_nxt     = 8'd0;
      mal_nxt    = 1'b0;
      lit_nxt    = 1'b0;
      depth_nxt  = '0;
      err_nxt    = ST_OK;
    end

    if (cnt != '0) res_v[cnt - 2'd1].last = 1'b1;
    step.count = cnt;
    step.item  = res_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_NORMAL;
      quotes_r <= 1'b0;
      lo_r     <= 8'd0;
      hi_r     <= 8'd0;
      mal_r    <= 1'b0;
      lit_r    <= 1'b0;
      depth_r  <= '0;
      err_r    <= ST_OK;
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      quotes_r <= quotes_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      mal_r    <= mal_nxt;
      lit_r    <= lit_nxt;
      depth_r  <= depth_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpt_fifo.sv =====
// Result queue: takes up to three results per cycle and hands them out one
// per cycle in order while pop is high. Depends on rpt_pkg.
`default_nettype none

module rpt_fifo
  import rpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  step_t     push_data,
  input  wire logic pop,
  output logic      room,
  output logic      not_empty,
  output res_t      head
);

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] push_n;

  assign push_n    = push ? LVL_W'(push_data.count) : '0;
  assign level_nxt = level_r + push_n - (pop ? LVL_W'(1) : LVL_W'(0));
  assign room      = (level_r <= LVL_W'(FIFO_DEPTH - MAX_RES));
  assign not_empty = (level_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push && RES_CNT_W'(i) < push_data.count) begin
        mem_r[wr_ptr_r + PTR_W'(i)] <= push_data.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      level_r <= level_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/regex_pattern_tokenizer.sv =====
// Top level of the regex pattern tokenizer: step logic and result queue.
// Depends on rpt_pkg, rpt_core and rpt_fifo.
//
// Usage: pattern bytes enter on the in_ channel (in_ch, with in_end_of_text
// on the final byte of a pattern). Each accepted request yields zero to three
// result requests on the out_ channel; out_last marks the final result of a
// byte. The byte flagged end_of_text always yields a final status result and
// returns the tokenizer to its start state for the next pattern.
// Results of a byte enter the result queue when the byte is taken and are
// offered on the out_ channel in order behind any earlier results.
// Throughput: one byte per cycle while results drain at least as fast as
// they are made; the output port moves one result per cycle while out_ready
// is high. The eight-entry result queue sets the figure: in_ready is high
// while at least three entries are free.
// Reset: synchronous, active low; the queue empties and all tokenizer state
// returns to its start values.
// Stall: when out_ready is low the results wait in the queue; once it has
// fewer than three free entries, in_ready drops until results are taken.
`default_nettype none

module regex_pattern_tokenizer
  import rpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_token,
  output logic [7:0]      out_first_char,
  output logic [7:0]      out_second_char,
  output logic            out_starts_literal,
  output logic [2:0]      out_status,
  output logic            out_last
);

  logic  accept;
  logic  room;
  step_t step;
  res_t  head;

  assign in_ready = room;
  assign accept   = in_valid && room;

  rpt_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (accept),
    .ch          (in_ch),
    .end_of_text (in_end_of_text),
    .step        (step)
  );

  rpt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step),
    .pop       (out_valid && out_ready),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_token          = head.token;
  assign out_first_char     = head.first_char;
  assign out_second_char    = head.second_char;
  assign out_starts_literal = head.starts_literal;
  assign out_status         = head.status;
  assign out_last           = head.last;

endmodule

`default_nettype wire

// ===== bench/rpt_token_checker.sv =====
// Token checker for the regex pattern tokenizer: watches both channels, predicts the
// tokens of every accepted byte and compares them with the results taken from the block.
// Depends on rpt_pkg for the result record, token, status and character codes.
`timescale 1ns / 100ps

module rpt_token_checker
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] out_token,
  input  logic [7:0] out_first_char,
  input  logic [7:0] out_second_char,
  input  logic       out_starts_literal,
  input  logic [2:0] out_status,
  input  logic       out_last,
  output int         fail_count,
  output int         tokens_pending
);

  typedef enum logic [2:0] {
    SCAN_PLAIN,
    SCAN_ESCAPE,
    SCAN_RANGE_LO,
    SCAN_RANGE_DASH,
    SCAN_RANGE_HI,
    SCAN_RANGE_CLOSE
  } scan_e;

  scan_e                 scan;
  logic                  quoted;
  logic                  lit_open;
  logic                  malformed;
  logic [7:0]            lo_byte;
  logic [7:0]            hi_byte;
  logic [DEPTH_BITS-1:0] depth;
  logic [2:0]            err;

  res_t byte_tokens[$];
  res_t expected_tokens[$];

  task automatic clear_scan();
    scan = SCAN_PLAIN;
    quoted = 1'b0;
    lit_open = 1'b0;
    malformed = 1'b0;
    lo_byte = 8'd0;
    hi_byte = 8'd0;
    depth = '0;
    err = ST_OK;
  endtask

  task automatic add_token(input logic [3:0] tk, input logic [7:0] c1, input logic [7:0] c2,
                           input logic start, input logic [2:0] st);
    res_t r;
    r.token = tk;
    r.first_char = c1;
    r.second_char = c2;
    r.starts_literal = start;
    r.status = st;
    r.last = 1'b0;
    byte_tokens.push_back(r);
  endtask

  task automatic add_literal(input logic [7:0] c);
    add_token(TK_LIT, c, 8'd0, !lit_open, ST_OK);
    lit_open = 1'b1;
  endtask

  task automatic add_operator(input logic [3:0] tk);
    lit_open = 1'b0;
    add_token(tk, 8'd0, 8'd0, 1'b0, ST_OK);
  endtask

  task automatic scan_plain(input logic [7:0] c);
    if (c == CH_BACKSLASH) begin
      scan = SCAN_ESCAPE;
    end else if (c == CH_QUOTE) begin
      quoted = !quoted;
    end else if (quoted) begin
      add_literal(c);
    end else begin
      case (c)
        CH_LBRACKET: begin
          lit_open = 1'b0;
          scan = SCAN_RANGE_LO;
        end
        CH_RBRACKET: err = ST_STRAY_BRACKET;
        CH_LPAREN: begin
          depth = depth + DEPTH_BITS'(1);
          add_operator(TK_OPEN);
        end
        CH_RPAREN: begin
          depth = depth - DEPTH_BITS'(1);
          add_operator(TK_CLOSE);
        end
        CH_BAR:   add_operator(TK_ALT);
        CH_STAR:  add_operator(TK_STAR);
        CH_PLUS:  add_operator(TK_PLUS);
        CH_QUEST: add_operator(TK_QUEST);
        CH_DOT:   add_operator(TK_WILD);
        default:  add_literal(c);
      endcase
    end
  endtask

  task automatic scan_escape(input logic [7:0] c);
    scan = SCAN_PLAIN;
    if (c == CH_QUOTE || c == CH_BACKSLASH) begin
      add_literal(c);
    end else if (quoted) begin
      add_literal(CH_BACKSLASH);
      add_literal(c);
    end else begin
      case (c)
        CH_LOW_S: add_operator(TK_SPACE);
        CH_LOW_E: add_operator(TK_EMPTY);
        CH_LOW_T: add_literal(CH_TAB);
        CH_LOW_R: add_literal(CH_CR);
        CH_LOW_N: add_literal(CH_LF);
        default: ;
      endcase
    end
  endtask

  task automatic scan_range(input logic [7:0] c);
    case (scan)
      SCAN_RANGE_LO: begin
        lo_byte = c;
        scan = SCAN_RANGE_DASH;
      end
      SCAN_RANGE_DASH: begin
        malformed = (c != CH_DASH);
        scan = SCAN_RANGE_HI;
      end
      SCAN_RANGE_HI: begin
        hi_byte = c;
        scan = SCAN_RANGE_CLOSE;
      end
      default: begin
        scan = SCAN_PLAIN;
        if (malformed || c != CH_RBRACKET) err = ST_BAD_RANGE;
        else add_token(TK_RANGE, lo_byte, hi_byte, 1'b0, ST_OK);
      end
    endcase
  endtask

  task automatic tokenize_byte(input logic [7:0] c, input logic eot);
    logic [2:0] outcome;
    res_t       r;
    if (err == ST_OK) begin
      if (scan == SCAN_ESCAPE) scan_escape(c);
      else if (scan == SCAN_PLAIN) scan_plain(c);
      else scan_range(c);
    end
    if (eot) begin
      outcome = err;
      if (outcome == ST_OK) begin
        if (scan == SCAN_ESCAPE) outcome = ST_TRAIL_ESC;
        else if (scan != SCAN_PLAIN) outcome = ST_UNFINISHED;
        else if (depth != '0) outcome = depth[DEPTH_BITS-1] ? ST_EXTRA_CLOSE : ST_EXTRA_OPEN;
        else if (quoted) outcome = ST_OPEN_QUOTE;
      end
      add_token(TK_FINAL, 8'd0, 8'd0, 1'b0, outcome);
      clear_scan();
    end
    if (byte_tokens.size() > 0) begin
      r = byte_tokens.pop_back();
      r.last = 1'b1;
      byte_tokens.push_back(r);
    end
    while (byte_tokens.size() > 0) expected_tokens.push_back(byte_tokens.pop_front());
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (expected_tokens.size() == 0) begin
      $error("token %0d taken with no request waiting for it", out_token);
      fail_count++;
    end else begin
      want = expected_tokens.pop_front();
      check_field("token", 8'(want.token), 8'(out_token));
      check_field("first_char", want.first_char, out_first_char);
      check_field("second_char", want.second_char, out_second_char);
      check_field("starts_literal", 8'(want.starts_literal), 8'(out_starts_literal));
      check_field("status", 8'(want.status), 8'(out_status));
      check_field("last", 8'(want.last), 8'(out_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_tokens.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) tokenize_byte(in_ch, in_end_of_text);
    end
    tokens_pending = expected_tokens.size();
  end

endmodule

// ===== bench/regex_pattern_tokenizer_test.sv =====
// Top of the regex pattern tokenizer bench: clock, reset, pattern stimulus, result
// back-pressure and the verdict. Depends on rpt_pkg, the tokenizer RTL and rpt_token_checker.
`timescale 1ns / 100ps

module regex_pattern_tokenizer_test;
  import rpt_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_BYTES = 64;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'd0;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_token;
  logic [7:0] out_first_char;
  logic [7:0] out_second_char;
  logic       out_starts_literal;
  logic [2:0] out_status;
  logic       out_last;

  int   mismatches;
  int   tokens_pending;
  int   send_idle_pct = 15;
  int   recv_idle_pct = 49;
  int   bytes_sent = 0;
  int   quiet_cycles = 0;
  bit   hold_req = 1'b0;
  logic [7:0] pattern_bytes[$];

  always #1 clk = ~clk;

  regex_pattern_tokenizer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token          (out_token),
    .out_first_char     (out_first_char),
    .out_second_char    (out_second_char),
    .out_starts_literal (out_starts_literal),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  rpt_token_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token          (out_token),
    .out_first_char     (out_first_char),
    .out_second_char    (out_second_char),
    .out_starts_literal (out_starts_literal),
    .out_status         (out_status),
    .out_last           (out_last),
    .fail_count         (mismatches),
    .tokens_pending     (tokens_pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_pattern();
    int n;
    for (n = 0; n < pattern_bytes.size(); n++) begin
      send_byte(pattern_bytes[n], n == pattern_bytes.size() - 1);
    end
    pattern_bytes.delete();
  endtask

  task automatic queue_text(input string s);
    int n;
    for (n = 0; n < s.len(); n++) pattern_bytes.push_back(s[n]);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(4))
      0: return CH_BAR;
      1: return CH_STAR;
      2: return CH_PLUS;
      3: return CH_QUEST;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic logic [7:0] pick_escaped();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_BACKSLASH;
      2: return CH_LOW_S;
      3: return CH_LOW_E;
      4: return CH_LOW_T;
      5: return CH_LOW_R;
      6: return CH_LOW_N;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic build_random_pattern();
    int         pieces;
    int         opens;
    logic [7:0] b;
    opens = 0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) pattern_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    pieces = $urandom_range(1, 7);
    repeat (pieces) begin
      case ($urandom_range(9))
        0, 1: repeat ($urandom_range(1, 3)) pattern_bytes.push_back(8'($urandom_range(97, 122)));
        2: pattern_bytes.push_back(pick_operator());
        3: begin
          pattern_bytes.push_back(CH_BACKSLASH);
          pattern_bytes.push_back(pick_escaped());
        end
        4: begin
          pattern_bytes.push_back(CH_LBRACKET);
          pattern_bytes.push_back(8'($urandom_range(255)));
          pattern_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : CH_DASH);
          pattern_bytes.push_back(8'($urandom_range(255)));
          pattern_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                           : CH_RBRACKET);
        end
        5: begin
          pattern_bytes.push_back(CH_LPAREN);
          opens++;
        end
        6: begin
          pattern_bytes.push_back(CH_RPAREN);
          if (opens > 0) opens--;
        end
        7: begin
          pattern_bytes.push_back(CH_QUOTE);
          repeat ($urandom_range(3)) begin
            b = 8'($urandom_range(255));
            if (b == CH_QUOTE) b = CH_LOW_N;
            pattern_bytes.push_back(b);
          end
          pattern_bytes.push_back(CH_QUOTE);
        end
        8: pattern_bytes.push_back(8'($urandom_range(255)));
        default: pattern_bytes.push_back(8'($urandom_range(128, 255)));
      endcase
    end
    if ($urandom_range(3) != 0) repeat (opens) pattern_bytes.push_back(CH_RPAREN);
  endtask

  initial begin : stimulus
    int phase;
    int target;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pattern_bytes.push_back(8'h00);
    queue_text("(|*+?.");
    pattern_bytes.push_back(8'hFF);
    queue_text(")");
    send_pattern();
    queue_text("\\s\\e\"\\q\"");
    send_pattern();
    queue_text("]x");
    send_pattern();
    queue_text(")");
    send_pattern();
    queue_text("(");
    send_pattern();
    queue_text("\"");
    send_pattern();
    queue_text("\\");
    send_pattern();
    queue_text("[");
    send_pattern();
    queue_text("[a+b]");
    send_pattern();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_random_pattern();
        send_pattern();
      end
    end
    in_valid <= 1'b0;

    while (tokens_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
